// ----- rtl/core/pit_pkg.sv -----
`timescale 1ns / 1ps
// pit_pkg: shared constants for the point-in-triangle test unit
// no dependencies

package pit_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int TOL_BITS       = 16;
    localparam int DATA_BITS      = 32;
    localparam int ADDR_BITS      = 3;
    localparam int TOL_ADDR       = 0;

    localparam logic REG_TOLERANCE = 1'b0;

endpackage

// ----- rtl/core/pit_cfg.sv -----
`timescale 1ns / 1ps
// pit_cfg: apb register file holding the tolerance register
// depends on pit_pkg

module pit_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pit_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [pit_pkg::DATA_BITS-1:0]     pwdata,
    output logic [pit_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready,
    output logic [pit_pkg::TOL_BITS-1:0]      o_tolerance
);

    logic [pit_pkg::TOL_BITS-1:0] r_tolerance;
    logic                         w_index;

    assign w_index = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= '0;
        end else if (psel && penable && pwrite && w_index == pit_pkg::REG_TOLERANCE) begin
            r_tolerance <= pwdata[pit_pkg::TOL_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_index == pit_pkg::REG_TOLERANCE) begin
            prdata[pit_pkg::TOL_BITS-1:0] = r_tolerance;
        end
    end

    assign o_tolerance = r_tolerance;

endmodule

// ----- rtl/core/pit_front.sv -----
`timescale 1ns / 1ps
// pit_front: edge vectors, dot products and edge cross product (two stages)
// depends on pit_pkg

module pit_front #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [COORD_BITS-1:0]        i_a [3],
    input  logic signed [COORD_BITS-1:0]        i_b [3],
    input  logic signed [COORD_BITS-1:0]        i_c [3],
    input  logic signed [COORD_BITS-1:0]        i_q [3],
    output logic                                o_valid,
    output logic signed [2*COORD_BITS+3:0]      o_d00,
    output logic signed [2*COORD_BITS+3:0]      o_d01,
    output logic signed [2*COORD_BITS+3:0]      o_d02,
    output logic signed [2*COORD_BITS+3:0]      o_d11,
    output logic signed [2*COORD_BITS+3:0]      o_d12,
    output logic signed [2*COORD_BITS+2:0]      o_cr [3],
    output logic signed [COORD_BITS:0]          o_w [3]
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int LW = 2 * COORD_BITS + 4;
    localparam int XW = 2 * COORD_BITS + 3;

    logic                 r_v1, r_v2;
    logic signed [DW-1:0] r_e0 [3];
    logic signed [DW-1:0] r_e1 [3];
    logic signed [DW-1:0] r_w1 [3];
    logic signed [DW-1:0] r_w2 [3];
    logic signed [LW-1:0] r_d00, r_d01, r_d02, r_d11, r_d12;
    logic signed [XW-1:0] r_cr [3];

    logic signed [PW-1:0] n_p00 [3];
    logic signed [PW-1:0] n_p01 [3];
    logic signed [PW-1:0] n_p02 [3];
    logic signed [PW-1:0] n_p11 [3];
    logic signed [PW-1:0] n_p12 [3];
    logic signed [PW-1:0] n_xa  [3];
    logic signed [PW-1:0] n_xb  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p00[i] = r_e0[i] * r_e0[i];
            n_p01[i] = r_e0[i] * r_e1[i];
            n_p02[i] = r_e0[i] * r_w1[i];
            n_p11[i] = r_e1[i] * r_e1[i];
            n_p12[i] = r_e1[i] * r_w1[i];
        end
        n_xa[0] = r_e0[1] * r_e1[2];
        n_xb[0] = r_e0[2] * r_e1[1];
        n_xa[1] = r_e0[2] * r_e1[0];
        n_xb[1] = r_e0[0] * r_e1[2];
        n_xa[2] = r_e0[0] * r_e1[1];
        n_xb[2] = r_e0[1] * r_e1[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e0[i] <= DW'(i_b[i]) - DW'(i_a[i]);
                r_e1[i] <= DW'(i_c[i]) - DW'(i_a[i]);
                r_w1[i] <= DW'(i_q[i]) - DW'(i_a[i]);
                r_w2[i] <= r_w1[i];
                r_cr[i] <= XW'(n_xa[i]) - XW'(n_xb[i]);
            end
            r_d00 <= LW'(n_p00[0]) + LW'(n_p00[1]) + LW'(n_p00[2]);
            r_d01 <= LW'(n_p01[0]) + LW'(n_p01[1]) + LW'(n_p01[2]);
            r_d02 <= LW'(n_p02[0]) + LW'(n_p02[1]) + LW'(n_p02[2]);
            r_d11 <= LW'(n_p11[0]) + LW'(n_p11[1]) + LW'(n_p11[2]);
            r_d12 <= LW'(n_p12[0]) + LW'(n_p12[1]) + LW'(n_p12[2]);
        end
    end

    assign o_valid = r_v2;
    assign o_d00   = r_d00;
    assign o_d01   = r_d01;
    assign o_d02   = r_d02;
    assign o_d11   = r_d11;
    assign o_d12   = r_d12;
    assign o_cr    = r_cr;
    assign o_w     = r_w2;

endmodule

// ----- rtl/core/pit_back.sv -----
`timescale 1ns / 1ps
// pit_back: triple product, barycentric numerators and final compares (five stages)
// depends on pit_pkg

module pit_back #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [pit_pkg::TOL_BITS-1:0]        i_tolerance,
    input  logic                                i_valid,
    input  logic signed [2*COORD_BITS+3:0]      i_d00,
    input  logic signed [2*COORD_BITS+3:0]      i_d01,
    input  logic signed [2*COORD_BITS+3:0]      i_d02,
    input  logic signed [2*COORD_BITS+3:0]      i_d11,
    input  logic signed [2*COORD_BITS+3:0]      i_d12,
    input  logic signed [2*COORD_BITS+2:0]      i_cr [3],
    input  logic signed [COORD_BITS:0]          i_w [3],
    output logic                                o_valid,
    output logic                                o_inside
);

    localparam int TB = pit_pkg::TOL_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int LW = 2 * COORD_BITS + 4;
    localparam int XW = 2 * COORD_BITS + 3;
    localparam int TW = 3 * COORD_BITS + 6;
    localparam int SW = 2 * LW;
    localparam int QW = 4 * COORD_BITS + 9;
    localparam int MW = LW + TB + 1;
    localparam int HW = QW - 32;
    localparam int CW = QW + 18;

    logic signed [TB:0] w_t;
    assign w_t = $signed({1'b0, i_tolerance});

    // stage 3
    logic                 r_v3, r_mz3;
    logic signed [TW-1:0] r_trip;
    logic signed [LW-1:0] r_m;
    logic signed [SW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [DW+XW-1:0] n_tp [3];
    logic signed [LW-1:0] n_m;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_tp[i] = i_w[i] * i_cr[i];
        end
        n_m = (i_d00 > i_d11) ? i_d00 : i_d11;
    end

    // stage 4
    logic                 r_v4, r_mz4;
    logic signed [TW-1:0] r_tabs;
    logic signed [MW-1:0] r_tm;
    logic signed [QW-1:0] r_den4, r_un4, r_vn4;

    // stage 5
    logic                 r_v5, r_bad5;
    logic [TB+31:0]       r_tlo;
    logic signed [HW+TB:0] r_thi;
    logic signed [QW-1:0] r_den5, r_un5, r_vn5;

    // stage 6
    logic                 r_v6, r_bad6;
    logic signed [CW-1:0] r_td;
    logic signed [QW-1:0] r_den6, r_un6, r_vn6;

    // stage 7, also the output register
    logic                 r_v7, r_ok;

    logic signed [CW-1:0] n_c1, n_c2, n_lhs, n_rhs;

    always_comb begin
        n_c1  = (CW'(r_un6) <<< 8) + r_td;
        n_c2  = (CW'(r_vn6) <<< 8) + r_td;
        n_lhs = (CW'(r_den6) <<< 8) + r_td;
        n_rhs = (CW'(r_un6) + CW'(r_vn6)) <<< 8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trip <= TW'(n_tp[0]) + TW'(n_tp[1]) + TW'(n_tp[2]);
            r_m    <= n_m;
            r_mz3  <= (n_m == '0);
            r_p0   <= i_d00 * i_d11;
            r_p1   <= i_d01 * i_d01;
            r_p2   <= i_d11 * i_d02;
            r_p3   <= i_d01 * i_d12;
            r_p4   <= i_d00 * i_d12;
            r_p5   <= i_d01 * i_d02;

            r_tabs <= r_trip[TW-1] ? -r_trip : r_trip;
            r_tm   <= w_t * r_m;
            r_den4 <= QW'(r_p0) - QW'(r_p1);
            r_un4  <= QW'(r_p2) - QW'(r_p3);
            r_vn4  <= QW'(r_p4) - QW'(r_p5);
            r_mz4  <= r_mz3;

            r_bad5 <= r_mz4 || (CW'(r_tabs) > CW'(r_tm)) || (r_den4 == '0);
            r_tlo  <= i_tolerance * r_den4[31:0];
            r_thi  <= w_t * r_den4[QW-1:32];
            r_den5 <= r_den4;
            r_un5  <= r_un4;
            r_vn5  <= r_vn4;

            r_td   <= (CW'(r_thi) <<< 32) + CW'($signed({1'b0, r_tlo}));
            r_bad6 <= r_bad5;
            r_den6 <= r_den5;
            r_un6  <= r_un5;
            r_vn6  <= r_vn5;

            r_ok   <= !r_bad6 && (n_c1 > 0) && (n_c2 > 0) && (n_lhs > n_rhs);
        end
    end

    assign o_valid  = r_v7;
    assign o_inside = r_ok;

endmodule

// ----- rtl/core/point_in_triangle_test_unit.sv -----
`timescale 1ns / 1ps
// point_in_triangle_test_unit: top level of the point-in-triangle test
// depends on pit_pkg, pit_cfg, pit_front, pit_back
//
// usage:
//   input channel (i_valid / o_ready) carries one triangle a, b, c and a
//   query point q per beat, signed fixed point, COORD_BITS per coordinate
//   output channel (o_valid / i_ready) returns one inside flag per beat
//   apb port holds the tolerance register at address 0 (unsigned q8.8)
// timing:
//   seven-stage pipeline; each beat runs through pit_front and then pit_back
//   one beat per cycle sustained unless a stall holds it; the last stage is the output register
// reset:
//   synchronous active-low reset clears all valid bits and the tolerance
// stall:
//   when the output holds a flag and i_ready is low the whole pipeline
//   freezes and o_ready drops; nothing is dropped or repeated
//   write the tolerance only while the pipeline is empty

module point_in_triangle_test_unit #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pit_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [pit_pkg::DATA_BITS-1:0]     pwdata,
    output logic [pit_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_BITS-1:0]      i_vertex_a_x,
    input  logic signed [COORD_BITS-1:0]      i_vertex_a_y,
    input  logic signed [COORD_BITS-1:0]      i_vertex_a_z,
    input  logic signed [COORD_BITS-1:0]      i_vertex_b_x,
    input  logic signed [COORD_BITS-1:0]      i_vertex_b_y,
    input  logic signed [COORD_BITS-1:0]      i_vertex_b_z,
    input  logic signed [COORD_BITS-1:0]      i_vertex_c_x,
    input  logic signed [COORD_BITS-1:0]      i_vertex_c_y,
    input  logic signed [COORD_BITS-1:0]      i_vertex_c_z,
    input  logic signed [COORD_BITS-1:0]      i_query_x,
    input  logic signed [COORD_BITS-1:0]      i_query_y,
    input  logic signed [COORD_BITS-1:0]      i_query_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_inside_res
);

    logic                          w_en;
    logic [pit_pkg::TOL_BITS-1:0]  w_tol;
    logic signed [COORD_BITS-1:0]  w_a [3];
    logic signed [COORD_BITS-1:0]  w_b [3];
    logic signed [COORD_BITS-1:0]  w_c [3];
    logic signed [COORD_BITS-1:0]  w_q [3];

    logic                          w_fv;
    logic signed [2*COORD_BITS+3:0] w_d00, w_d01, w_d02, w_d11, w_d12;
    logic signed [2*COORD_BITS+2:0] w_cr [3];
    logic signed [COORD_BITS:0]     w_w [3];

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    assign w_a[0] = i_vertex_a_x;
    assign w_a[1] = i_vertex_a_y;
    assign w_a[2] = i_vertex_a_z;
    assign w_b[0] = i_vertex_b_x;
    assign w_b[1] = i_vertex_b_y;
    assign w_b[2] = i_vertex_b_z;
    assign w_c[0] = i_vertex_c_x;
    assign w_c[1] = i_vertex_c_y;
    assign w_c[2] = i_vertex_c_z;
    assign w_q[0] = i_query_x;
    assign w_q[1] = i_query_y;
    assign w_q[2] = i_query_z;

    pit_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_tolerance (w_tol)
    );

    pit_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .i_q     (w_q),
        .o_valid (w_fv),
        .o_d00   (w_d00),
        .o_d01   (w_d01),
        .o_d02   (w_d02),
        .o_d11   (w_d11),
        .o_d12   (w_d12),
        .o_cr    (w_cr),
        .o_w     (w_w)
    );

    pit_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_tolerance (w_tol),
        .i_valid     (w_fv),
        .i_d00       (w_d00),
        .i_d01       (w_d01),
        .i_d02       (w_d02),
        .i_d11       (w_d11),
        .i_d12       (w_d12),
        .i_cr        (w_cr),
        .i_w         (w_w),
        .o_valid     (o_valid),
        .o_inside    (o_inside_res)
    );

endmodule
